[src/hds_pkg.sv]
// Shared constants and field widths for the heat diffusion stencil core.
`timescale 1ns / 1ps

package hds_pkg;

    // Payload and configuration widths.
    localparam int VALUE_W     = 32;
    localparam int COEFF_W     = 16;
    localparam int GRID_W_W    = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // Fixed-point arithmetic: the Laplacian needs three guard bits over a cell value.
    localparam int Q_FRAC = 16;
    localparam int LAP_W  = VALUE_W + 3;
    localparam int PROD_W = LAP_W + COEFF_W + 1;
    localparam int DELTA_W = PROD_W - Q_FRAC;
    localparam int SUM_W  = DELTA_W + 1;

    // Line store depth and register reset values.
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int GRID_WIDTH_MIN    = 3;
    localparam logic [COEFF_W-1:0]  COEFF_RESET      = 16'd66;
    localparam logic [GRID_W_W-1:0] GRID_WIDTH_RESET = 11'd1024;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSION_COEFF = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH      = 1'd1;

endpackage

[src/hds_line_buf.sv]
// Two line stores (upper and middle row) with registered reads.
`timescale 1ns / 1ps

module hds_line_buf
    import hds_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEFAULT
)(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_col,
    input  logic [$clog2(DEPTH)-1:0]   rd_col_right,
    input  logic signed [VALUE_W-1:0]  wr_value,
    input  logic                       wb_en,
    input  logic [$clog2(DEPTH)-1:0]   wb_col,
    output logic signed [VALUE_W-1:0]  centre,
    output logic signed [VALUE_W-1:0]  right,
    output logic signed [VALUE_W-1:0]  up
);

    logic signed [VALUE_W-1:0] mid_mem [DEPTH];
    logic signed [VALUE_W-1:0] up_mem  [DEPTH];

    logic signed [VALUE_W-1:0] mid_c_rd_reg;
    logic signed [VALUE_W-1:0] mid_r_rd_reg;
    logic signed [VALUE_W-1:0] up_rd_reg;
    logic signed [VALUE_W-1:0] fwd_data_reg;
    logic                      fwd_sel_reg;

    // Middle row: read the cell and its right neighbor, then store the new cell.
    // The read returns the old contents when the write hits the same entry.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mid_c_rd_reg    <= mid_mem[rd_col];
            mid_r_rd_reg    <= mid_mem[rd_col_right];
            mid_mem[rd_col] <= wr_value;
        end
    end

    // Upper row: the old middle value moves up in the cycle after the read.
    // A write still in flight to the entry being read is forwarded.
    always_ff @(posedge clk)
    begin
        if (wb_en)
        begin
            up_mem[wb_col] <= mid_c_rd_reg;
        end
        if (rd_en)
        begin
            up_rd_reg    <= up_mem[rd_col];
            fwd_sel_reg  <= wb_en && (wb_col == rd_col);
            fwd_data_reg <= mid_c_rd_reg;
        end
    end

    assign centre = mid_c_rd_reg;
    assign right  = mid_r_rd_reg;
    assign up     = fwd_sel_reg ? fwd_data_reg : up_rd_reg;

endmodule

[src/heat_diffusion_stencil_step_core.sv]
// Top level of the five-point heat equation stencil step core.
//
// Cells of a grid enter row-major on the input channel (cell_value, frame_end),
// one beat per cycle while in_ready is high. When the cell at row r, column c
// is taken, the core later delivers the updated value of cell (r-1, c) on the
// output channel, with row_last and frame_last marking the end of a row and of
// the grid. The first row produces no output, the second row and the first and
// last columns pass their stored values through, and the bottom row is never
// delivered. Two line stores in block memory hold the two previous rows.
// A result passes through the stage 1, stage 2 and stage 3 registers and then
// the output register after the edge that accepted its input beat. Throughput:
// one beat per cycle unless the receiver stalls. Reset clears the row and column
// tracking, empties the pipeline and loads diffusion_coeff = 66 and grid_width =
// 1024; line stores are not cleared. When the receiver stalls, finished results
// wait in the output register and bubbles inside the pipeline still fill; in_ready
// drops only once every stage is occupied. Configuration writes must only be made
// while the core is idle.
`timescale 1ns / 1ps

module heat_diffusion_stencil_step_core
    import hds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [VALUE_W-1:0]  cell_value,
    input  logic                       frame_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  new_value,
    output logic                       row_last,
    output logic                       frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_BULK
    } phase_t;

    // Configuration registers.
    logic [COEFF_W-1:0]  coeff_reg;
    logic [GRID_W_W-1:0] grid_width_reg;

    // Row tracking.
    phase_t              phase_reg;
    logic [AW-1:0]       col_reg;
    logic [CW-1:0]       eff_width;
    logic [AW-1:0]       last_col;
    logic                row_end_in;
    logic [AW-1:0]       col_in;
    logic [AW-1:0]       col_right;
    logic                accept;

    // Stage 1: memory read data.
    logic                      s1_valid_reg;
    logic [AW-1:0]             s1_col_reg;
    logic                      s1_row_end_reg;
    logic                      s1_frame_end_reg;
    logic                      s1_emit_reg;
    logic                      s1_interior_reg;
    logic signed [VALUE_W-1:0] s1_down_reg;
    logic signed [VALUE_W-1:0] left_reg;
    logic signed [VALUE_W-1:0] centre;
    logic signed [VALUE_W-1:0] right;
    logic signed [VALUE_W-1:0] up;
    logic                      s1_leave;
    logic                      s1_take;

    // Stage 2: Laplacian.
    logic                      s2_valid_reg;
    logic signed [LAP_W-1:0]   s2_lap_reg;
    logic signed [LAP_W-1:0]   s2_lap_next;
    logic signed [VALUE_W-1:0] s2_centre_reg;
    logic                      s2_interior_reg;
    logic                      s2_row_last_reg;
    logic                      s2_frame_last_reg;
    logic                      s2_leave;
    logic                      s2_take;

    // Stage 3: product with the diffusion coefficient.
    logic                      s3_valid_reg;
    logic signed [PROD_W-1:0]  s3_prod_reg;
    logic signed [PROD_W-1:0]  s3_prod_next;
    logic signed [VALUE_W-1:0] s3_centre_reg;
    logic                      s3_interior_reg;
    logic                      s3_row_last_reg;
    logic                      s3_frame_last_reg;
    logic                      s3_leave;
    logic                      s3_take;

    // Output register.
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] new_value_reg;
    logic signed [VALUE_W-1:0] new_value_next;
    logic                      row_last_reg;
    logic                      frame_last_reg;
    logic                      out_take;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic signed [COEFF_W:0]   coeff_s;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg      <= COEFF_RESET;
            grid_width_reg <= GRID_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIFFUSION_COEFF: coeff_reg      <= cfg_data[COEFF_W-1:0];
                REG_GRID_WIDTH:      grid_width_reg <= cfg_data[GRID_W_W-1:0];
                default:             coeff_reg      <= coeff_reg;
            endcase
        end
    end

    // Row width clamped between GRID_WIDTH_MIN and the line store depth.
    always_comb
    begin
        if (int'(grid_width_reg) < GRID_WIDTH_MIN)
        begin
            eff_width = CW'(GRID_WIDTH_MIN);
        end
        else if (int'(grid_width_reg) > MAX_WIDTH)
        begin
            eff_width = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = CW'(grid_width_reg);
        end
    end

    assign last_col   = AW'(eff_width - CW'(1));
    assign row_end_in = (col_reg >= last_col);
    assign col_in     = row_end_in ? last_col : col_reg;
    assign col_right  = row_end_in ? col_in : col_in + AW'(1);
    assign accept     = in_valid && in_ready;

    // Column and row phase tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            col_reg   <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                phase_reg <= PH_FIRST;
                col_reg   <= '0;
            end
            else if (row_end_in)
            begin
                col_reg <= '0;
                case (phase_reg)
                    PH_FIRST:  phase_reg <= PH_SECOND;
                    PH_SECOND: phase_reg <= PH_BULK;
                    default:   phase_reg <= PH_BULK;
                endcase
            end
            else
            begin
                col_reg <= col_in + AW'(1);
            end
        end
    end

    // Line stores.
    hds_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk          (clk),
        .rd_en        (accept),
        .rd_col       (col_in),
        .rd_col_right (col_right),
        .wr_value     (cell_value),
        .wb_en        (s1_valid_reg),
        .wb_col       (s1_col_reg),
        .centre       (centre),
        .right        (right),
        .up           (up)
    );

    // Handshake between stages: a stage advances when the next one can take it.
    assign out_take = !out_valid_reg || out_ready;
    assign s3_leave = s3_valid_reg && out_take;
    assign s3_take  = !s3_valid_reg || s3_leave;
    assign s2_leave = s2_valid_reg && s3_take;
    assign s2_take  = !s2_valid_reg || s2_leave;
    assign s1_leave = s1_valid_reg && (!s1_emit_reg || s2_take);
    assign s1_take  = !s1_valid_reg || s1_leave;
    assign in_ready = s1_take;

    // Stage 1 control and payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= col_in;
            s1_row_end_reg   <= row_end_in;
            s1_frame_end_reg <= frame_end;
            s1_emit_reg      <= (phase_reg != PH_FIRST);
            s1_interior_reg  <= (phase_reg == PH_BULK) && (col_in != '0) && !row_end_in;
            s1_down_reg      <= cell_value;
        end
        // The left neighbor is the centre of the previous cell in the row.
        if (s1_leave)
        begin
            left_reg <= centre;
        end
    end

    // Stage 2: sum of the four neighbors minus four times the centre.
    assign s2_lap_next = LAP_W'(up) + LAP_W'(s1_down_reg) + LAP_W'(left_reg)
                       + LAP_W'(right) - (LAP_W'(centre) <<< 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            s2_valid_reg <= s1_leave && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_leave && s1_emit_reg && s2_take)
        begin
            s2_lap_reg        <= s2_lap_next;
            s2_centre_reg     <= centre;
            s2_interior_reg   <= s1_interior_reg;
            s2_row_last_reg   <= s1_row_end_reg;
            s2_frame_last_reg <= s1_frame_end_reg;
        end
    end

    // Stage 3: scale by the unsigned Q0.16 coefficient.
    assign coeff_s      = $signed({1'b0, coeff_reg});
    assign s3_prod_next = s2_lap_reg * coeff_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_take)
        begin
            s3_valid_reg <= s2_leave;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_leave)
        begin
            s3_prod_reg       <= s3_prod_next;
            s3_centre_reg     <= s2_centre_reg;
            s3_interior_reg   <= s2_interior_reg;
            s3_row_last_reg   <= s2_row_last_reg;
            s3_frame_last_reg <= s2_frame_last_reg;
        end
    end

    // Interior cells: arithmetic shift of the product, add to the centre, saturate.
    assign delta = s3_prod_reg[PROD_W-1:Q_FRAC];
    assign sum   = SUM_W'(s3_centre_reg) + SUM_W'(delta);

    always_comb
    begin
        if (!s3_interior_reg)
        begin
            new_value_next = s3_centre_reg;
        end
        else if (sum > SUM_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}})))
        begin
            new_value_next = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (sum < -SUM_W'(signed'({1'b0, 1'b1, {(VALUE_W-1){1'b0}}})))
        begin
            new_value_next = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            new_value_next = sum[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= s3_leave;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_leave)
        begin
            new_value_reg  <= new_value_next;
            row_last_reg   <= s3_row_last_reg;
            frame_last_reg <= s3_frame_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_value  = new_value_reg;
    assign row_last   = row_last_reg;
    assign frame_last = frame_last_reg;

endmodule

[src/hds_checker.sv]
// Port-level checks for the stencil core, bound to the top level.
`timescale 1ns / 1ps

module hds_checker
    import hds_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [VALUE_W-1:0]  new_value,
    input logic                       row_last,
    input logic                       frame_last
);

    logic        in_beat;
    logic        out_beat;
    logic [31:0] pending_reg;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Input beats not yet matched by an output beat (saturating).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat && (pending_reg != '1))
        begin
            pending_reg <= pending_reg + 32'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 32'd1;
        end
    end

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(new_value)
                                       && $stable(row_last) && $stable(frame_last)))
        else $error("output beat changed while stalled");

    // With the receiver ready, the pipeline never holds off the sender.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

    // No result without an input beat that caused it.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("result without a pending input beat");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind heat_diffusion_stencil_step_core hds_checker u_hds_checker (.*);

[test/heat_stencil_checker.sv]
// Checker that predicts and compares the stencil core's output beats.
`timescale 1ns / 1ps

module heat_stencil_checker
    import hds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [VALUE_W-1:0] cell_value,
    input  logic                      frame_end,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [VALUE_W-1:0] new_value,
    input  logic                      row_last,
    input  logic                      frame_last,
    output int                        fail_count,
    output int                        pending_results
);

    typedef enum logic [1:0] {FIRST_ROW, SECOND_ROW, INNER_ROWS} row_stage_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      row_last;
        logic                      frame_last;
    } stencil_out_t;

    localparam longint SAT_MAX = 64'sd2147483647;
    localparam longint SAT_MIN = -64'sd2147483648;

    // Private copy of the line stores, row tracking and registers.
    logic signed [VALUE_W-1:0] line_above   [MAX_WIDTH];
    logic signed [VALUE_W-1:0] line_current [MAX_WIDTH];
    int unsigned               col_pos;
    row_stage_t                row_stage;
    logic [COEFF_W-1:0]        coeff;
    logic [GRID_W_W-1:0]       width_reg;
    stencil_out_t              expected_cells [$];

    initial
    begin
        fail_count      = 0;
        pending_results = 0;
    end

    // Advance the stencil by one cell and queue the result it produces, if any.
    task automatic predict_cell(input logic signed [VALUE_W-1:0] cell_in,
                                input logic last_of_frame);
        int unsigned  span;
        int unsigned  c;
        logic         at_row_end;
        longint       centre;
        longint       lap;
        longint       updated;
        stencil_out_t res;
        begin
            if (width_reg < GRID_WIDTH_MIN)
                span = GRID_WIDTH_MIN;
            else if (width_reg > MAX_WIDTH)
                span = MAX_WIDTH;
            else
                span = width_reg;

            // A column past the row end is folded onto the last column.
            c = col_pos;
            at_row_end = (c >= span - 1);
            if (at_row_end)
                c = span - 1;

            if (row_stage != FIRST_ROW)
            begin
                centre  = line_current[c];
                updated = centre;
                if (row_stage == INNER_ROWS && c != 0 && !at_row_end)
                begin
                    // The left neighbor has already moved into the upper line.
                    lap = longint'(line_above[c]) + longint'(cell_in)
                        + longint'(line_above[c - 1]) + longint'(line_current[c + 1])
                        - 4 * centre;
                    updated = centre + ((lap * longint'(coeff)) >>> Q_FRAC);
                    if (updated > SAT_MAX)
                        updated = SAT_MAX;
                    if (updated < SAT_MIN)
                        updated = SAT_MIN;
                end
                res.value      = updated[VALUE_W-1:0];
                res.row_last   = at_row_end;
                res.frame_last = last_of_frame;
                expected_cells.push_back(res);
            end

            line_above[c]   = line_current[c];
            line_current[c] = cell_in;

            if (last_of_frame)
            begin
                col_pos   = 0;
                row_stage = FIRST_ROW;
            end
            else if (at_row_end)
            begin
                col_pos = 0;
                if (row_stage == FIRST_ROW)
                    row_stage = SECOND_ROW;
                else
                    row_stage = INNER_ROWS;
            end
            else
            begin
                col_pos = c + 1;
            end
        end
    endtask

    // Watch both channels and the register port on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        stencil_out_t oldest;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                line_above[i]   = '0;
                line_current[i] = '0;
            end
            col_pos   = 0;
            row_stage = FIRST_ROW;
            coeff     = COEFF_RESET;
            width_reg = GRID_WIDTH_RESET;
            expected_cells.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIFFUSION_COEFF: coeff     = cfg_data[COEFF_W-1:0];
                    REG_GRID_WIDTH:      width_reg = cfg_data[GRID_W_W-1:0];
                    default: ;
                endcase
            end

            // Output beats are compared against the oldest prediction.
            if (out_valid && out_ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: output beat with nothing expected: ", $time,
                                 "value %0d row_last %0b frame_last %0b",
                                 new_value, row_last, frame_last);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_cells.pop_front();
                    if (oldest.value !== new_value || oldest.row_last !== row_last
                        || oldest.frame_last !== frame_last)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: expected value %0d row_last %0b ",
                                     $time, oldest.value, oldest.row_last,
                                     "frame_last %0b, got value %0d row_last %0b ",
                                     oldest.frame_last, new_value, row_last,
                                     "frame_last %0b", frame_last);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                predict_cell(cell_value, frame_end);
        end
        pending_results = expected_cells.size();
    end

endmodule

[test/tb_heat_diffusion_stencil_step_core.sv]
// Testbench top for the heat diffusion stencil core: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_step_core;
    import hds_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_CELLS  = 160;

    localparam logic signed [VALUE_W-1:0] CELL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] CELL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] cell_value;
    logic                      frame_end;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [VALUE_W-1:0] new_value;
    logic                      row_last;
    logic                      frame_last;

    int fail_count;
    int pending_results;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cells_sent         = 0;
    int quiet_cycles       = 0;
    int cur_span           = MAX_WIDTH_DEFAULT;

    heat_diffusion_stencil_step_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_value (cell_value),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_value  (new_value),
        .row_last   (row_last),
        .frame_last (frame_last)
    );

    heat_stencil_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cell_value      (cell_value),
        .frame_end       (frame_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .new_value       (new_value),
        .row_last        (row_last),
        .frame_last      (frame_last),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // End the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_heat_diffusion_stencil_step_core failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one input beat, after a random idle gap, and wait until it is taken.
    task automatic send_cell(input logic signed [VALUE_W-1:0] value, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cell_value <= value;
        frame_end  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        cells_sent++;
    endtask

    // Hold the sender until every predicted beat has come out and the pipe is empty.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Write the grid width; the unused upper data bits carry noise.
    task automatic load_width(input int unsigned raw);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[GRID_W_W-1:0] = raw[GRID_W_W-1:0];
        if (raw < GRID_WIDTH_MIN)
            cur_span = GRID_WIDTH_MIN;
        else if (raw > MAX_WIDTH_DEFAULT)
            cur_span = MAX_WIDTH_DEFAULT;
        else
            cur_span = raw;
        write_reg(REG_GRID_WIDTH, word);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_cell();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return CELL_MAX;
            1:       return CELL_MIN;
            2:       return CELL_MAX - $urandom_range(255);
            3:       return CELL_MIN + $urandom_range(255);
            4, 5:    return r;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coeff();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned random_span();
        case ($urandom_range(9))
            0:       return $urandom_range(0, 2);
            1, 2:    return $urandom_range(13, 40);
            default: return $urandom_range(3, 12);
        endcase
    endfunction

    // One frame: mostly whole rows, sometimes cut short, sometimes narrowed mid-frame.
    task automatic run_random_frame();
        int n;
        int cut_at;
        if ($urandom_range(99) < 40)
        begin
            drain_results();
            if ($urandom_range(1))
                write_reg(REG_DIFFUSION_COEFF, random_coeff());
            if ($urandom_range(1))
                load_width(random_span());
        end
        n = $urandom_range(1, 6) * cur_span;
        if ($urandom_range(99) < 20)
            n = $urandom_range(1, n + cur_span);
        cut_at = ($urandom_range(99) < 10 && n > 1) ? $urandom_range(1, n - 1) : 0;
        for (int k = 0; k < n; k++)
        begin
            // Narrowing only: every line entry read afterwards was written in this frame.
            if (k == cut_at && k != 0)
            begin
                drain_results();
                load_width($urandom_range(0, cur_span - 1));
            end
            send_cell(random_cell(), k == n - 1);
        end
    endtask

    initial
    begin : stimulus
        logic signed [VALUE_W-1:0] sat_grid [12];
        int idle_plan  [5];
        int stall_plan [5];
        int target;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cell_value = '0;
        frame_end  = 1'b0;
        out_ready  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Frame ending inside its first row, at reset settings: no output.
        send_cell(CELL_MAX, 1'b0);
        send_cell(CELL_MIN, 1'b1);

        // Narrowest grid, largest coefficient: both saturation directions.
        drain_results();
        write_reg(REG_DIFFUSION_COEFF, '1);
        load_width(GRID_WIDTH_MIN);
        sat_grid = '{CELL_MAX, CELL_MAX, CELL_MAX,
                     CELL_MAX, CELL_MIN, CELL_MAX,
                     CELL_MIN, CELL_MAX, CELL_MIN,
                     CELL_MIN, CELL_MIN, CELL_MIN};
        for (int k = 0; k < 12; k++)
            send_cell(sat_grid[k], k == 11);

        // Zero coefficient leaves interior cells unchanged.
        drain_results();
        write_reg(REG_DIFFUSION_COEFF, '0);
        for (int k = 0; k < 9; k++)
            send_cell(random_cell(), k == 8);

        // Random frames under each idling pattern.
        idle_plan  = '{0, 81, 0, 22, 0};
        stall_plan = '{0, 0, 81, 22, 0};
        for (int p = 0; p < 5; p++)
        begin
            sender_idle_pct    = idle_plan[p];
            receiver_stall_pct = stall_plan[p];
            target = cells_sent + PHASE_CELLS;
            while (cells_sent < target)
                run_random_frame();
        end

        // Widest grid via an out-of-range width: one full row and the start of the next.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        drain_results();
        write_reg(REG_DIFFUSION_COEFF, CFG_DATA_W'($urandom));
        load_width(2047);
        for (int k = 0; k < cur_span + 3; k++)
            send_cell(random_cell(), k == cur_span + 2);

        // Another over-range width, with a short frame that stays in its first row.
        drain_results();
        load_width($urandom_range(MAX_WIDTH_DEFAULT + 1, 2046));
        for (int k = 0; k < 5; k++)
            send_cell(random_cell(), k == 4);

        drain_results();
        if (fail_count == 0 && pending_results == 0)
            $display("tb_heat_diffusion_stencil_step_core passed");
        else
            $display("tb_heat_diffusion_stencil_step_core failed");
        $finish;
    end

endmodule

[files.f]
src/hds_pkg.sv
src/hds_line_buf.sv
src/heat_diffusion_stencil_step_core.sv
src/hds_checker.sv
test/heat_stencil_checker.sv
test/tb_heat_diffusion_stencil_step_core.sv
